// File: rtl/trd_pkg.sv
`default_nettype none

package trd_pkg;

   // fixed field widths
   localparam int AXIS_W     = 16;
   localparam int MAG_W      = 16;
   localparam int SQ_W       = 32;
   localparam int SQRT_STEPS = 16;
   localparam int REG_W      = 16;
   localparam int CSR_IDX_W  = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEADZONE_RADIUS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE      = 1'd1;

   // register reset values
   localparam logic [REG_W-1:0] RADIUS_RESET = 16'd7849;
   localparam logic [REG_W-1:0] MAX_RESET    = 16'd32767;

   // per-word context carried down the pipe
   typedef struct packed {
      logic [AXIS_W-1:0] ax;
      logic [AXIS_W-1:0] ay;
      logic              neg_x;
      logic              neg_y;
   } ctx_type;

endpackage

`default_nettype wire

// File: rtl/thumbstick_radial_deadzone.sv
`default_nettype none

// Radial deadzone scaling for one thumbstick. Each accepted word (stick_x,
// stick_y) gives the floor integer square root of x*x+y*y as its magnitude; at
// or below deadzone_radius, or when the full-scale distance (register 1) is not
// above the radius, both outputs are zero, otherwise the magnitude is clamped to
// the full-scale distance, the radius taken off and the result divided by
// (full scale - radius) into an unsigned Q1.FRACTION_BITS factor that scales
// each axis, truncated toward zero.
// The pipe takes one word every cycle unless every stage is full and the output
// is stalled. Stages: one each for the absolute values, the squares and their
// sum, sixteen restoring square root stages, a clamp stage, FRACTION_BITS+1
// restoring divide stages, the axis multiply and the output register. A stalled
// result holds only the words queued behind it; bubbles further up still close
// up, so input is taken while a result waits as long as a stage is free. Write
// registers only with the pipe empty; the block itself does not enforce this.
module thumbstick_radial_deadzone
   import trd_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   // configuration
   input  wire                        csr_we,
   input  wire       [CSR_IDX_W-1:0]  csr_index,
   input  wire       [REG_W-1:0]      csr_data,
   // sample in
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire signed [AXIS_W-1:0]    req_stick_x,
   input  wire signed [AXIS_W-1:0]    req_stick_y,
   // result out
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic signed [AXIS_W-1:0]   rsp_scaled_x,
   output logic signed [AXIS_W-1:0]   rsp_scaled_y
);

   // stage map
   localparam int ST_ABS  = 0;
   localparam int ST_SQR  = 1;
   localparam int ST_SUM  = 2;
   localparam int ST_RT0  = 3;
   localparam int ST_CLMP = ST_RT0 + SQRT_STEPS;
   localparam int ST_DV0  = ST_CLMP + 1;
   localparam int DV_STEPS = FRACTION_BITS + 1;
   localparam int ST_MUL  = ST_DV0 + DV_STEPS;
   localparam int ST_OUT  = ST_MUL + 1;
   localparam int NS      = ST_OUT + 1;

   localparam int FAC_W  = FRACTION_BITS + 1;
   localparam int PROD_W = AXIS_W + FAC_W;
   localparam int REM_W  = MAG_W + 1;   // square root remainder

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [REG_W-1:0] radius_ff;
   logic [REG_W-1:0] max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         max_ff    <= MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEADZONE_RADIUS: radius_ff <= csr_data;
            REG_FULL_SCALE:      max_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pipe control: a stage holds when it and every stage after it is
   // full and the output is stalled, so bubbles collapse
   // ---------------------------------------------------------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] hold;

   assign vld_in = {vld_ff[NS-2:0], req_valid};

   for (genvar s = 0; s < NS; s++) begin : g_hold
      localparam logic [NS-1:0] LOW_MASK = ~({NS{1'b1}} << s);
      assign hold[s] = rsp_stall & (&(vld_ff | LOW_MASK));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (!hold[s]) vld_ff[s] <= vld_in[s];
         end
      end
   end

   assign req_stall = hold[ST_ABS];
   assign rsp_valid = vld_ff[ST_OUT];

   // ---------------------------------------------------------------
   // context line: absolute axes and signs
   // ---------------------------------------------------------------
   ctx_type ctx_ff [ST_MUL+1];
   ctx_type ctx_in;

   always_comb begin
      ctx_in.neg_x = req_stick_x[AXIS_W-1];
      ctx_in.neg_y = req_stick_y[AXIS_W-1];
      ctx_in.ax    = req_stick_x[AXIS_W-1] ? $unsigned(-req_stick_x) : $unsigned(req_stick_x);
      ctx_in.ay    = req_stick_y[AXIS_W-1] ? $unsigned(-req_stick_y) : $unsigned(req_stick_y);
   end

   always_ff @(posedge clock) begin
      if (!hold[ST_ABS]) ctx_ff[ST_ABS] <= ctx_in;
      for (int s = 1; s <= ST_MUL; s++) begin
         if (!hold[s]) ctx_ff[s] <= ctx_ff[s-1];
      end
   end

   // ---------------------------------------------------------------
   // squares and their sum
   // ---------------------------------------------------------------
   logic [SQ_W-1:0] sq_x_ff, sq_y_ff, sum_ff;
   logic [SQ_W-1:0] sq_x_in, sq_y_in;

   assign sq_x_in = SQ_W'(ctx_ff[ST_ABS].ax) * SQ_W'(ctx_ff[ST_ABS].ax);
   assign sq_y_in = SQ_W'(ctx_ff[ST_ABS].ay) * SQ_W'(ctx_ff[ST_ABS].ay);

   always_ff @(posedge clock) begin
      if (!hold[ST_SQR]) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
      end
      if (!hold[ST_SUM]) sum_ff <= sq_x_ff + sq_y_ff;
   end

   // ---------------------------------------------------------------
   // restoring square root, two radicand bits per stage
   // ---------------------------------------------------------------
   logic [SQ_W-1:0]  rt_rad_ff  [SQRT_STEPS-1];
   logic [REM_W-1:0] rt_rem_ff  [SQRT_STEPS-1];
   logic [MAG_W-1:0] rt_root_ff [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      logic [SQ_W-1:0]  rad;
      logic [REM_W-1:0] rem;
      logic [MAG_W-1:0] root;
      logic [REM_W+1:0] rem_sh;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      logic             take;
      logic [REM_W-1:0] rem_in;
      logic [MAG_W-1:0] root_in;

      if (j == 0) begin : g_first
         assign rad  = sum_ff;
         assign rem  = '0;
         assign root = '0;
      end else begin : g_next
         assign rad  = rt_rad_ff[j-1];
         assign rem  = rt_rem_ff[j-1];
         assign root = rt_root_ff[j-1];
      end

      always_comb begin
         rem_sh  = {rem, rad[SQ_W-1 -: 2]};
         trial   = {1'b0, root, 2'b01};
         diff    = rem_sh - trial;
         take    = (rem_sh >= trial);
         rem_in  = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_in = {root[MAG_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (!hold[ST_RT0+j]) rt_root_ff[j] <= root_in;
      end

      if (j < SQRT_STEPS-1) begin : g_carry
         always_ff @(posedge clock) begin
            if (!hold[ST_RT0+j]) begin
               rt_rad_ff[j] <= rad << 2;
               rt_rem_ff[j] <= rem_in;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // deadzone test and clamp
   // ---------------------------------------------------------------
   logic [MAG_W-1:0] mag;
   logic [MAG_W-1:0] clamped;
   logic             cl_ok_in;
   logic [REG_W-1:0] cl_num_ff, cl_den_ff;
   logic             cl_ok_ff;

   always_comb begin
      mag      = rt_root_ff[SQRT_STEPS-1];
      clamped  = (mag > max_ff) ? max_ff : mag;
      cl_ok_in = (mag > radius_ff) && (max_ff > radius_ff);
   end

   always_ff @(posedge clock) begin
      if (!hold[ST_CLMP]) begin
         cl_num_ff <= clamped - radius_ff;
         cl_den_ff <= max_ff - radius_ff;
         cl_ok_ff  <= cl_ok_in;
      end
   end

   // ---------------------------------------------------------------
   // restoring divide, one quotient bit per stage; num <= den, so the
   // quotient fits FRACTION_BITS+1 bits
   // ---------------------------------------------------------------
   logic [REG_W-1:0] dv_rem_ff [DV_STEPS-1];
   logic [REG_W-1:0] dv_den_ff [DV_STEPS-1];
   logic [FAC_W-1:0] dv_q_ff   [DV_STEPS];
   logic             dv_ok_ff  [DV_STEPS];

   for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
      logic [REG_W:0]   rem;
      logic [REG_W-1:0] den;
      logic [FAC_W-1:0] q;
      logic             ok;
      logic             take;
      logic [REG_W:0]   diff;
      logic [REG_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem = {1'b0, cl_num_ff};
         assign den = cl_den_ff;
         assign q   = '0;
         assign ok  = cl_ok_ff;
      end else begin : g_next
         assign rem = {dv_rem_ff[k-1], 1'b0};
         assign den = dv_den_ff[k-1];
         assign q   = dv_q_ff[k-1];
         assign ok  = dv_ok_ff[k-1];
      end

      always_comb begin
         take   = (rem >= {1'b0, den});
         diff   = rem - {1'b0, den};
         rem_in = take ? diff[REG_W-1:0] : rem[REG_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (!hold[ST_DV0+k]) begin
            dv_q_ff[k]  <= {q[FAC_W-2:0], take};
            dv_ok_ff[k] <= ok;
         end
      end

      if (k < DV_STEPS-1) begin : g_carry
         always_ff @(posedge clock) begin
            if (!hold[ST_DV0+k]) begin
               dv_rem_ff[k] <= rem_in;
               dv_den_ff[k] <= den;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // axis multiply and output register
   // ---------------------------------------------------------------
   logic [FAC_W-1:0]  factor;
   logic [PROD_W-1:0] prod_x_ff, prod_y_ff;
   logic [AXIS_W-1:0] mag_x, mag_y;

   assign factor = dv_ok_ff[DV_STEPS-1] ? dv_q_ff[DV_STEPS-1] : '0;

   always_ff @(posedge clock) begin
      if (!hold[ST_MUL]) begin
         prod_x_ff <= PROD_W'(ctx_ff[ST_MUL-1].ax) * PROD_W'(factor);
         prod_y_ff <= PROD_W'(ctx_ff[ST_MUL-1].ay) * PROD_W'(factor);
      end
   end

   // the product never exceeds the axis, so sixteen bits above the point suffice
   assign mag_x = prod_x_ff[FRACTION_BITS +: AXIS_W];
   assign mag_y = prod_y_ff[FRACTION_BITS +: AXIS_W];

   always_ff @(posedge clock) begin
      if (!hold[ST_OUT]) begin
         rsp_scaled_x <= ctx_ff[ST_MUL].neg_x ? $signed(-mag_x) : $signed(mag_x);
         rsp_scaled_y <= ctx_ff[ST_MUL].neg_y ? $signed(-mag_y) : $signed(mag_y);
      end
   end

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // an accepted word lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[ST_ABS])
      else $error("accepted word did not enter the pipe");

   // a held stage keeps its word
   a_held_kept: assert property (@(posedge clock) disable iff (reset)
      hold[ST_CLMP] |=> vld_ff[ST_CLMP] && $stable(cl_num_ff))
      else $error("held clamp stage lost its word");

   // the factor never exceeds one
   a_factor_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_MUL-1] && dv_ok_ff[DV_STEPS-1] |->
         dv_q_ff[DV_STEPS-1] <= (FAC_W'(1) << FRACTION_BITS))
      else $error("scale factor above one");

   // scaled magnitude never exceeds the raw axis
   a_no_growth: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_MUL] |-> mag_x <= ctx_ff[ST_MUL].ax && mag_y <= ctx_ff[ST_MUL].ay)
      else $error("scaled axis larger than raw axis");

   // inside the deadzone the axis products are zero
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_MUL-1] && !dv_ok_ff[DV_STEPS-1] && !hold[ST_MUL]
         |=> prod_x_ff == '0 && prod_y_ff == '0)
      else $error("nonzero output inside deadzone");

endmodule

`default_nettype wire

// File: dv/thumbstick_radial_deadzone_tb.sv
`timescale 1ns / 1ps

module thumbstick_radial_deadzone_tb
   import trd_pkg::*;
();

   localparam int FRAC        = 16;
   localparam int CYCLE_LIMIT = 400000;
   // long enough to cover the last word with room to spare
   localparam int SETTLE      = 3 * (FRAC + 22);
   localparam int HOLD_CYCLES = 300;

   // one stick word, used for both the sample and the scaled result
   typedef struct packed {
      logic signed [AXIS_W-1:0] x;
      logic signed [AXIS_W-1:0] y;
   } axis_pair_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic       [CSR_IDX_W-1:0] csr_index = '0;
   logic       [REG_W-1:0]     csr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [AXIS_W-1:0]   req_stick_x = '0;
   logic signed [AXIS_W-1:0]   req_stick_y = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [AXIS_W-1:0]   rsp_scaled_x;
   logic signed [AXIS_W-1:0]   rsp_scaled_y;

   // local copy of the two range registers, as last written
   logic [REG_W-1:0] radius_q = 16'd7849;
   logic [REG_W-1:0] max_dist_q = 16'd32767;

   // scaled words still owed by the pipe, oldest first
   axis_pair_type pending_scaled[$];

   // idling switches and the long receiver hold-off request
   bit send_idling = 1'b1;
   bit recv_idling = 1'b1;
   bit hold_off_pending = 1'b0;

   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned words_sent = 0;
   int unsigned results_checked = 0;
   int unsigned settings_used = 0;
   int unsigned input_held = 0;

   thumbstick_radial_deadzone #(
      .FRACTION_BITS (FRAC)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_stick_x  (req_stick_x),
      .req_stick_y  (req_stick_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_scaled_x (rsp_scaled_x),
      .rsp_scaled_y (rsp_scaled_y)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("thumbstick_radial_deadzone_tb NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // |a| * factor, truncated, sign put back afterwards
   function automatic logic [AXIS_W-1:0] axis_product(input longint a,
                                                      input longint unsigned factor);
      longint unsigned size;
      longint unsigned prod;
      size = (a < 0) ? longint'(-a) : longint'(a);
      prod = (size * factor) >> FRAC;
      if (a < 0)
         prod = -prod;
      return prod[AXIS_W-1:0];
   endfunction

   function automatic axis_pair_type deadzone_scale(input axis_pair_type s);
      longint            sx;
      longint            sy;
      longint unsigned   ax;
      longint unsigned   ay;
      longint unsigned   sq_sum;
      longint unsigned   root;
      longint unsigned   trial;
      longint unsigned   clamped;
      longint unsigned   factor;
      axis_pair_type     res;
      sx = s.x;
      sy = s.y;
      ax = (sx < 0) ? longint'(-sx) : longint'(sx);
      ay = (sy < 0) ? longint'(-sy) : longint'(sy);
      sq_sum = ax * ax + ay * ay;
      // floor root, one bit at a time from the top; sum < 2^32 so 17 bits suffice
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= sq_sum)
            root = trial;
      end
      // zero inside the deadzone, on its edge, and for an empty range
      factor = 0;
      if (root > radius_q && max_dist_q > radius_q) begin
         clamped = (root > max_dist_q) ? max_dist_q : root;
         factor = ((clamped - radius_q) << FRAC) / (max_dist_q - radius_q);
      end
      res.x = axis_product(sx, factor);
      res.y = axis_product(sy, factor);
      return res;
   endfunction

   // ---------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------

   always @(posedge clock) begin : check_results
      axis_pair_type want;
      if (!reset) begin
         if (req_valid && req_stall)
            input_held++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_scaled.size() == 0) begin
               $display("%0t: unexpected word x=%0d y=%0d", $time,
                        rsp_scaled_x, rsp_scaled_y);
               mismatches++;
            end else begin
               want = pending_scaled.pop_front();
               results_checked++;
               if (rsp_scaled_x !== want.x) begin
                  $display("%0t: scaled_x expected %0d got %0d", $time,
                           want.x, rsp_scaled_x);
                  mismatches++;
               end
               if (rsp_scaled_y !== want.y) begin
                  $display("%0t: scaled_y expected %0d got %0d", $time,
                           want.y, rsp_scaled_y);
                  mismatches++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver back-pressure: random stall bursts, plus one long hold-off
   // counted here on request
   // ---------------------------------------------------------------

   always begin : rsp_backpressure
      int unsigned stall_len;
      @(posedge clock);
      stall_len = 0;
      if (hold_off_pending) begin
         hold_off_pending = 1'b0;
         stall_len = HOLD_CYCLES;
      end else if (recv_idling && $urandom_range(0, 3) == 0) begin
         stall_len = $urandom_range(1, 14);
      end
      if (stall_len > 0) begin
         rsp_stall <= 1'b1;
         repeat (stall_len) @(posedge clock);
      end
      rsp_stall <= 1'b0;
   end

   // ---------------------------------------------------------------
   // sending side
   // ---------------------------------------------------------------

   // offer one word, maybe after an idle burst, and return once it is taken
   task automatic send_word(input axis_pair_type s);
      if (send_idling && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_stick_x <= s.x;
      req_stick_y <= s.y;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_scaled.push_back(deadzone_scale(s));
      words_sent++;
   endtask

   // stop offering and wait for every owed word to come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_scaled.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both registers, back to back, with the pipe empty
   task automatic apply_range(input logic [REG_W-1:0] radius,
                              input logic [REG_W-1:0] max_dist);
      wait_for_drain();
      csr_we    <= 1'b1;
      csr_index <= REG_DEADZONE_RADIUS;
      csr_data  <= radius;
      @(posedge clock);
      csr_index <= REG_FULL_SCALE;
      csr_data  <= max_dist;
      @(posedge clock);
      csr_we     <= 1'b0;
      radius_q   = radius;
      max_dist_q = max_dist;
      settings_used++;
   endtask

   function automatic logic signed [AXIS_W-1:0] corner_value();
      case ($urandom_range(0, 5))
         0:       return 16'sh8000;
         1:       return 16'sh8001;
         2:       return -16'sd1;
         3:       return 16'sd0;
         4:       return 16'sd1;
         default: return 16'sh7fff;
      endcase
   endfunction

   // random sample, weighted towards the deadzone edge and the clamp point
   function automatic axis_pair_type random_sample();
      axis_pair_type     s;
      logic signed [AXIS_W-1:0] tmp;
      int                size;
      int                cap;
      int unsigned       kind;
      kind = $urandom_range(0, 5);
      case (kind)
         0, 1: begin
            s.x = AXIS_W'($urandom);
            s.y = AXIS_W'($urandom);
         end
         2, 3: begin
            // on an axis, a few counts either side of the radius or the max
            size = (kind == 2) ? int'(radius_q) : int'(max_dist_q);
            size = size + int'($urandom_range(0, 6)) - 3;
            if (size < 0)
               size = 0;
            if (size > 32767)
               size = 32767;
            s.x = AXIS_W'($urandom_range(0, 1) ? -size : size);
            s.y = AXIS_W'(int'($urandom_range(0, 2)) - 1);
            if ($urandom_range(0, 1)) begin
               tmp = s.x;
               s.x = s.y;
               s.y = tmp;
            end
         end
         4: begin
            cap = int'($urandom_range(0, 32767));
            s.x = AXIS_W'(int'($urandom_range(0, 2 * cap)) - cap);
            s.y = AXIS_W'(int'($urandom_range(0, 2 * cap)) - cap);
         end
         default: begin
            s.x = corner_value();
            s.y = corner_value();
         end
      endcase
      return s;
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // reset settings: origin, full scale, the deadzone edge and either side
   task automatic test_reset_defaults();
      send_word('{16'sd0, 16'sd0});
      send_word('{16'sd32767, 16'sd0});
      send_word('{-16'sd32768, 16'sd0});
      send_word('{16'sd0, -16'sd32768});
      send_word('{16'sd32767, 16'sd32767});
      send_word('{-16'sd32768, -16'sd32768});
      send_word('{-16'sd32768, 16'sd32767});
      // magnitude right on the radius, then one past it
      send_word('{16'sd7849, 16'sd0});
      send_word('{-16'sd7850, 16'sd0});
      send_word('{16'sd0, 16'sd7848});
      send_word('{16'sd3000, 16'sd4000});
      send_word('{16'sd20000, -16'sd15000});
      send_word('{16'sd1, -16'sd1});
   endtask

   // register extremes, including empty ranges and values past the stated range
   task automatic test_register_extremes();
      apply_range(16'd0, 16'd65535);
      send_word('{16'sd0, 16'sd0});
      send_word('{16'sd1, -16'sd1});
      send_word('{-16'sd32768, -16'sd32768});

      // steepest slope: magnitude 1 is already full scale
      apply_range(16'd0, 16'd1);
      send_word('{16'sd0, 16'sd0});
      send_word('{16'sd0, 16'sd1});
      send_word('{-16'sd32768, 16'sd32767});

      // max equal to radius, then below it: always zero
      apply_range(16'd65535, 16'd65535);
      send_word('{-16'sd32768, -16'sd32768});
      send_word('{16'sd32767, 16'sd0});
      apply_range(16'd100, 16'd50);
      send_word('{16'sd32767, -16'sd32768});

      // radius at the largest reachable magnitude
      apply_range(16'd46340, 16'd46341);
      send_word('{-16'sd32768, -16'sd32768});
      send_word('{-16'sd32768, -16'sd32767});
   endtask

   // a run of random settings, each with a stream of random words
   task automatic test_random_settings();
      logic [REG_W-1:0] radius;
      logic [REG_W-1:0] max_dist;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               radius   = REG_W'($urandom_range(0, 46340));
               max_dist = REG_W'(radius + $urandom_range(1, 46341 - radius));
            end
            1: begin
               radius   = REG_W'($urandom_range(0, 64));
               max_dist = REG_W'(radius + $urandom_range(1, 200));
            end
            2: begin
               radius   = REG_W'($urandom);
               max_dist = REG_W'($urandom);
            end
            3: begin
               radius   = 16'd0;
               max_dist = 16'd46341;
            end
            4: begin
               radius   = 16'd46341;
               max_dist = 16'd65535;
            end
            default: begin
               radius   = 16'd7849;
               max_dist = 16'd32767;
            end
         endcase
         apply_range(radius, max_dist);
         repeat (50) send_word(random_sample());
         // sender waits for everything owed before carrying on
         wait_for_drain();
         repeat (50) send_word(random_sample());
      end
   endtask

   // long receiver hold-off while words keep coming, so the pipe backs up
   task automatic test_hold_off();
      apply_range(16'd7849, 16'd32767);
      send_idling      = 1'b0;
      hold_off_pending = 1'b1;
      repeat (150) send_word(random_sample());
      wait_for_drain();
      send_idling = 1'b1;
   endtask

   // closing stretch at full rate, no idling on either side
   task automatic test_steady_stream();
      apply_range(REG_W'($urandom_range(0, 20000)), REG_W'($urandom_range(20001, 46341)));
      send_idling = 1'b0;
      recv_idling = 1'b0;
      repeat (150) send_word(random_sample());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_random_settings();
      test_hold_off();
      test_steady_stream();

      wait_for_drain();
      repeat (SETTLE) @(posedge clock);

      $display("%0d words sent under %0d register settings, %0d results checked",
               words_sent, settings_used + 1, results_checked);
      $display("input held back on %0d cycles, %0d mismatches", input_held, mismatches);
      if (mismatches == 0 && pending_scaled.size() == 0)
         $display("thumbstick_radial_deadzone_tb OK");
      else
         $display("thumbstick_radial_deadzone_tb NOT OK");
      $finish;
   end

endmodule
